### rtl/cc20_pkg.sv
// Package for the ChaCha20 keystream cipher unit.
// Holds the shared constants, the front-to-back request type and the quarter-round function.
// No dependencies.
package cc20_pkg;

  localparam int unsigned BlockBytes   = 64;
  localparam int unsigned ItemBytes    = 8;
  localparam int unsigned NumRounds    = 20;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  localparam logic [CfgIdxW-1:0] RegKey01   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey23   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey45   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey67   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonceLo = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonceHi = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInitCtr = 3'd6;

  // Request passed from the front part to the back part.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        restart;
  } cc20_req_t;

  typedef logic [15:0][31:0] cc20_state_t;

  function automatic logic [127:0] cc20_qr(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1;
    a1 = a + b;   d1 = d ^ a1;  d1 = {d1[15:0], d1[31:16]};
    c1 = c + d1;  b1 = b ^ c1;  b1 = {b1[19:0], b1[31:20]};
    a1 = a1 + b1; d1 = d1 ^ a1; d1 = {d1[23:0], d1[31:24]};
    c1 = c1 + d1; b1 = b1 ^ c1; b1 = {b1[24:0], b1[31:25]};
    return {a1, b1, c1, d1};
  endfunction

endpackage

### rtl/cc20_front.sv
// Front part: accepts items, saturates the count and queues them for the back part.
// Depends on cc20_pkg.
module cc20_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [63:0]         in_data_bytes,
  input  logic [3:0]          in_byte_count,
  input  logic                in_restart,
  output logic                req_valid,
  output cc20_pkg::cc20_req_t req,
  input  logic                req_take
);
  import cc20_pkg::*;

  cc20_req_t q_r [QueueDepth];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  cc20_req_t  w;
  logic       do_push;

  assign in_full   = (cnt_r == 2'(QueueDepth));
  assign do_push   = in_push && !in_full;
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rp_r];

  always_comb begin
    w.data    = in_data_bytes;
    w.count   = (in_byte_count > 4'(ItemBytes)) ? 4'(ItemBytes) : in_byte_count;
    w.restart = in_restart;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        q_r[wp_r] <= w;
        wp_r      <= ~wp_r;
      end
      if (req_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(req_take);
    end
  end
endmodule

### rtl/cc20_core.sv
// ChaCha20 block function: one column or diagonal round per cycle, then feed-forward.
// Depends on cc20_pkg.
module cc20_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  cc20_pkg::cc20_state_t   init,
  output logic                    done,
  output cc20_pkg::cc20_state_t   block
);
  import cc20_pkg::*;

  cc20_state_t x_r, ini_r, x_nxt;
  logic [4:0]  step_r;
  logic        busy_r;
  logic [127:0] q0, q1, q2, q3;

  // Even steps are column rounds, odd steps diagonal rounds.
  always_comb begin
    x_nxt = x_r;
    if (!step_r[0]) begin
      q0 = cc20_qr(x_r[0], x_r[4], x_r[8],  x_r[12]);
      q1 = cc20_qr(x_r[1], x_r[5], x_r[9],  x_r[13]);
      q2 = cc20_qr(x_r[2], x_r[6], x_r[10], x_r[14]);
      q3 = cc20_qr(x_r[3], x_r[7], x_r[11], x_r[15]);
      {x_nxt[0], x_nxt[4], x_nxt[8],  x_nxt[12]} = q0;
      {x_nxt[1], x_nxt[5], x_nxt[9],  x_nxt[13]} = q1;
      {x_nxt[2], x_nxt[6], x_nxt[10], x_nxt[14]} = q2;
      {x_nxt[3], x_nxt[7], x_nxt[11], x_nxt[15]} = q3;
    end else begin
      q0 = cc20_qr(x_r[0], x_r[5], x_r[10], x_r[15]);
      q1 = cc20_qr(x_r[1], x_r[6], x_r[11], x_r[12]);
      q2 = cc20_qr(x_r[2], x_r[7], x_r[8],  x_r[13]);
      q3 = cc20_qr(x_r[3], x_r[4], x_r[9],  x_r[14]);
      {x_nxt[0], x_nxt[5], x_nxt[10], x_nxt[15]} = q0;
      {x_nxt[1], x_nxt[6], x_nxt[11], x_nxt[12]} = q1;
      {x_nxt[2], x_nxt[7], x_nxt[8],  x_nxt[13]} = q2;
      {x_nxt[3], x_nxt[4], x_nxt[9],  x_nxt[14]} = q3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
        x_r    <= init;
        ini_r  <= init;
      end else if (busy_r) begin
        x_r    <= x_nxt;
        step_r <= step_r + 5'd1;
        if (step_r == 5'(NumRounds - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          for (int i = 0; i < 16; i++) block[i] <= x_nxt[i] + ini_r[i];
        end
      end
    end
  end
endmodule

### rtl/cc20_back.sv
// Back part: holds the keystream block, XORs item bytes and drives the result register.
// Depends on cc20_pkg and cc20_core.
module cc20_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  cc20_pkg::cc20_req_t req,
  output logic                req_take,
  input  logic [63:0]         key01,
  input  logic [63:0]         key23,
  input  logic [63:0]         key45,
  input  logic [63:0]         key67,
  input  logic [63:0]         nonce_lo,
  input  logic [31:0]         nonce_hi,
  input  logic [31:0]         init_ctr,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [63:0]         out_result_bytes,
  output logic [3:0]          out_result_count
);
  import cc20_pkg::*;

  // The keystream block is kept as sixteen little-endian words.
  cc20_state_t ks_r;
  logic [7:0]  ks_byte;
  logic [6:0]  pos_r;
  logic [31:0] ctr_r;
  logic        gen_r;
  logic        full_r;
  logic [63:0] acc_r;
  logic [3:0]  idx_r;
  logic        act_r;
  cc20_req_t   cur_r;

  logic        core_start, core_done;
  cc20_state_t init, blk;

  assign init = {nonce_hi, nonce_lo[63:32], nonce_lo[31:0], ctr_r,
                 key67[63:32], key67[31:0], key45[63:32], key45[31:0],
                 key23[63:32], key23[31:0], key01[63:32], key01[31:0],
                 Sigma3, Sigma2, Sigma1, Sigma0};

  assign req_take   = req_valid && !act_r;
  assign out_empty  = !full_r;
  assign core_start = act_r && !gen_r && (idx_r < cur_r.count) && pos_r[6];
  assign ks_byte    = ks_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8];

  cc20_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .init  (init),
    .done  (core_done),
    .block (blk)
  );

  // One byte per cycle unless refilling or stalled; one result write per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 7'(BlockBytes);
      ctr_r  <= '0;
      gen_r  <= 1'b0;
      full_r <= 1'b0;
      act_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (full_r && out_pop) full_r <= 1'b0;
      if (req_take) begin
        act_r <= 1'b1;
        cur_r <= req;
        idx_r <= '0;
        acc_r <= '0;
        if (req.restart) begin
          ctr_r <= init_ctr;
          pos_r <= 7'(BlockBytes);
        end
      end else if (act_r) begin
        if (core_start) begin
          gen_r <= 1'b1;
        end else if (gen_r) begin
          if (core_done) begin
            gen_r <= 1'b0;
            ks_r  <= blk;
            pos_r <= '0;
            ctr_r <= ctr_r + 32'd1;
          end
        end else if (idx_r < cur_r.count) begin
          if (idx_r[2:0] == 3'd7 || idx_r + 4'd1 == cur_r.count) begin
            if (!full_r || out_pop) begin
              acc_r[idx_r[2:0]*8 +: 8] <= cur_r.data[idx_r[2:0]*8 +: 8] ^ ks_byte;
              out_result_bytes <= acc_r | (64'(cur_r.data[idx_r[2:0]*8 +: 8]
                                  ^ ks_byte) << (idx_r[2:0]*8));
              out_result_count <= cur_r.count;
              full_r <= 1'b1;
              act_r  <= 1'b0;
              pos_r  <= pos_r + 7'd1;
              idx_r  <= idx_r + 4'd1;
            end
          end else begin
            acc_r[idx_r[2:0]*8 +: 8] <= cur_r.data[idx_r[2:0]*8 +: 8] ^ ks_byte;
            pos_r <= pos_r + 7'd1;
            idx_r <= idx_r + 4'd1;
          end
        end else if (!full_r || out_pop) begin
          // Zero count: empty result.
          out_result_bytes <= '0;
          out_result_count <= '0;
          full_r <= 1'b1;
          act_r  <= 1'b0;
        end
      end
    end
  end
endmodule

### rtl/chacha20_keystream_cipher_unit.sv
// Top level of the ChaCha20 keystream cipher unit: configuration registers, front and back.
// Depends on cc20_pkg, cc20_front, cc20_back and cc20_core.
//
//   Channel | Handshake           | Payload
//   in      | in_push / in_full   | in_data_bytes, in_byte_count, in_restart
//   out     | out_pop / out_empty | out_result_bytes, out_result_count
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item is first taken from the queue and then handled one byte per cycle while
// keystream is buffered. When the buffered block runs out, the next 64 bytes are made by
// a start, 20 rounds of one column or diagonal round each and a load. A waiting result
// holds the last byte of the next item. A two-entry queue lets new items enter while the
// back part works or the result waits. Synchronous reset empties the keystream and clears
// the counter, the configuration registers and the control state.
module chacha20_keystream_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_data_bytes,
  input  logic [3:0]  in_byte_count,
  input  logic        in_restart,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_result_bytes,
  output logic [3:0]  out_result_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cc20_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import cc20_pkg::*;

  logic [63:0] key01_r, key23_r, key45_r, key67_r, nlo_r;
  logic [31:0] nhi_r, ictr_r;
  logic        req_valid, req_take;
  cc20_req_t   req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r <= '0; key23_r <= '0; key45_r <= '0; key67_r <= '0;
      nlo_r   <= '0; nhi_r   <= '0; ictr_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKey01:   key01_r <= cfg_data;
        RegKey23:   key23_r <= cfg_data;
        RegKey45:   key45_r <= cfg_data;
        RegKey67:   key67_r <= cfg_data;
        RegNonceLo: nlo_r   <= cfg_data;
        RegNonceHi: nhi_r   <= cfg_data[31:0];
        RegInitCtr: ictr_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_bytes (in_data_bytes),
    .in_byte_count (in_byte_count),
    .in_restart    (in_restart),
    .req_valid     (req_valid),
    .req           (req),
    .req_take      (req_take)
  );

  cc20_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_valid),
    .req              (req),
    .req_take         (req_take),
    .key01            (key01_r),
    .key23            (key23_r),
    .key45            (key45_r),
    .key67            (key67_r),
    .nonce_lo         (nlo_r),
    .nonce_hi         (nhi_r),
    .init_ctr         (ictr_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_bytes (out_result_bytes),
    .out_result_count (out_result_count)
  );
endmodule

### bench/tb_chacha20_keystream_cipher_unit.sv
// Self-checking testbench for the ChaCha20 keystream cipher unit.
// Encrypts random and directed byte items against an in-bench ChaCha20 keystream predictor.
// Depends on cc20_pkg and chacha20_keystream_cipher_unit.

class cipher_scoreboard;
  logic [63:0] regs [7];
  logic [7:0]  ks_bytes [64];
  int unsigned ks_pos;
  logic [31:0] blk_ctr;
  logic [63:0] exp_bytes [$];
  logic [3:0]  exp_count [$];
  int unsigned errors;

  function new();
    foreach (regs[i]) regs[i] = '0;
    ks_pos = 64;
    blk_ctr = '0;
    errors = 0;
  endfunction

  function void write_reg(int unsigned idx, logic [63:0] val);
    if (idx >= 5) val[63:32] = '0;
    regs[idx] = val;
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void qround(ref logic [31:0] x[16], input int a, int b, int c, int d);
    x[a] += x[b]; x[d] ^= x[a]; x[d] = rotl(x[d], 16);
    x[c] += x[d]; x[b] ^= x[c]; x[b] = rotl(x[b], 12);
    x[a] += x[b]; x[d] ^= x[a]; x[d] = rotl(x[d], 8);
    x[c] += x[d]; x[b] ^= x[c]; x[b] = rotl(x[b], 7);
  endfunction

  function void refill_keystream();
    logic [31:0] init [16];
    logic [31:0] w [16];
    logic [31:0] v;
    init[0] = cc20_pkg::Sigma0; init[1] = cc20_pkg::Sigma1;
    init[2] = cc20_pkg::Sigma2; init[3] = cc20_pkg::Sigma3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = regs[i][31:0];
      init[5 + 2*i] = regs[i][63:32];
    end
    init[12] = blk_ctr;
    init[13] = regs[cc20_pkg::RegNonceLo][31:0];
    init[14] = regs[cc20_pkg::RegNonceLo][63:32];
    init[15] = regs[cc20_pkg::RegNonceHi][31:0];
    w = init;
    for (int r = 0; r < 10; r++) begin
      qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
      qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
      qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
      qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      v = w[i] + init[i];
      for (int j = 0; j < 4; j++) ks_bytes[4*i + j] = v[8*j +: 8];
    end
    blk_ctr = blk_ctr + 32'd1;
  endfunction

  // Notes an accepted item and queues its ciphertext.
  function void note_item(logic [63:0] data, logic [3:0] cnt, logic rst);
    logic [63:0] res;
    int unsigned n;
    res = '0;
    if (rst) begin
      blk_ctr = regs[cc20_pkg::RegInitCtr][31:0];
      ks_pos = 64;
    end
    n = (cnt > cc20_pkg::ItemBytes) ? cc20_pkg::ItemBytes : cnt;
    for (int i = 0; i < n; i++) begin
      if (ks_pos >= 64) begin
        refill_keystream();
        ks_pos = 0;
      end
      res[8*i +: 8] = data[8*i +: 8] ^ ks_bytes[ks_pos];
      ks_pos++;
    end
    exp_bytes.push_back(res);
    exp_count.push_back(4'(n));
  endfunction

  function void check_result(logic [63:0] got_bytes, logic [3:0] got_count);
    logic [63:0] eb;
    logic [3:0] ec;
    if (exp_bytes.size() == 0) begin
      $display("%0t: unexpected result bytes %h count %0d", $time, got_bytes, got_count);
      errors++;
      return;
    end
    eb = exp_bytes.pop_front();
    ec = exp_count.pop_front();
    if (got_bytes !== eb) begin
      $display("%0t: result bytes expected %h actual %h", $time, eb, got_bytes);
      errors++;
    end
    if (got_count !== ec) begin
      $display("%0t: result count expected %0d actual %0d", $time, ec, got_count);
      errors++;
    end
  endfunction
endclass

module tb_chacha20_keystream_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cc20_pkg::*;

  logic clk, rst_n;
  logic in_push, in_full, in_restart;
  logic [63:0] in_data_bytes;
  logic [3:0] in_byte_count;
  logic out_empty, out_pop;
  logic [63:0] out_result_bytes;
  logic [3:0] out_result_count;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0] cfg_data;

  cipher_scoreboard sb;
  int pop_idle_pct;
  int push_idle_pct;
  int hold_left;

  chacha20_keystream_cipher_unit uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic cfg_idle();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_item(logic [63:0] data, logic [3:0] cnt, logic rst);
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_bytes <= data;
    in_byte_count <= cnt;
    in_restart <= rst;
    do @(posedge clk); while (in_full);
    sb.note_item(data, cnt, rst);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (sb.exp_bytes.size() != 0) @(posedge clk);
    // Let the block settle before the next configuration change.
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [3:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 4'd8;
    if (r < 70) return 4'd0;
    if (r < 80) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(7, 1));
  endfunction

  // Receiver: pops with random idling, or holds off for a counted stretch of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) sb.check_result(out_result_bytes, out_result_count);
      if (hold_left > 0) begin
        out_pop   <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  initial begin
    logic [63:0] v;
    sb = new();
    rst_n = 0;
    in_push = 0; in_data_bytes = '0; in_byte_count = '0; in_restart = 0;
    out_pop = 0; cfg_valid = 0; cfg_index = RegKey01; cfg_data = '0;
    pop_idle_pct = 30; push_idle_pct = 30; hold_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // RFC 8439 block-function test vector: key 00..1f, nonce 00 00 00 09 00 00 00 4a 00..
    write_cfg(RegKey01, 64'h0706050403020100);
    write_cfg(RegKey23, 64'h0f0e0d0c0b0a0908);
    write_cfg(RegKey45, 64'h1716151413121110);
    write_cfg(RegKey67, 64'h1f1e1d1c1b1a1918);
    write_cfg(RegNonceLo, 64'h4a00000009000000);
    write_cfg(RegNonceHi, 64'h0);
    write_cfg(RegInitCtr, 64'h1);
    cfg_idle();

    push_item(64'h0, 4'd8, 1'b1);
    push_item('1, 4'd8, 1'b0);
    push_item(64'h0123456789abcdef, 4'd1, 1'b0);
    push_item(rand64(), 4'd0, 1'b0);
    push_item(rand64(), 4'd15, 1'b0);
    push_item(rand64(), 4'd9, 1'b0);
    for (int i = 0; i < 8; i++) push_item(rand64(), 4'd7, 1'b0);
    push_item(rand64(), 4'd0, 1'b1);
    push_item('1, 4'd3, 1'b0);
    push_item(rand64(), 4'd8, 1'b1);
    drain_results();

    // Counter wrap, all-ones key and nonce.
    for (int r = 0; r < 5; r++) write_cfg(CfgIdxW'(r), '1);
    write_cfg(RegNonceHi, '1);
    write_cfg(RegInitCtr, 64'hFFFF_FFFF);
    cfg_idle();
    for (int i = 0; i < 20; i++) push_item(rand64(), 4'd8, i == 0);

    // Receiver stalls long enough for the queue to back up into the input.
    hold_left = 300;
    for (int i = 0; i < 30; i++) push_item(rand64(), rand_count(), 1'b0);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 7; r++) begin
        v = (ph == 1) ? 64'h0 : rand64();
        write_cfg(CfgIdxW'(r), v);
      end
      cfg_idle();
      if (ph == 3) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end else begin
        push_idle_pct = 30;
        pop_idle_pct = 30;
      end
      for (int i = 0; i < 140; i++)
        push_item(rand64(), rand_count(), (i == 0) || ($urandom_range(99) < 4));
      drain_results();
    end

    drain_results();
    if (sb.errors == 0 && sb.exp_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
